// File: hw/rtl/lfs_pkg.sv
// Shared types and constants for the delimited line field splitter.
package lfs_pkg;

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_CHAR    = 3'd1,
		ST_FEND    = 3'd2,
		ST_OK      = 3'd3,
		ST_BEGIN   = 3'd4,
		ST_END     = 3'd5,
		ST_LONG    = 3'd6,
		ST_TIMEOUT = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		REG_TIMEOUT    = 2'd0,
		REG_MAX_LINE   = 2'd1,
		REG_MAX_FIELDS = 2'd2,
		REG_MAX_FLEN   = 2'd3
	} reg_idx_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam logic [15:0] TIMEOUT_RST    = 16'd1000;
	localparam logic [7:0]  MAX_LINE_RST   = 8'd64;
	localparam logic [4:0]  MAX_FIELDS_RST = 5'd8;
	localparam logic [6:0]  MAX_FLEN_RST   = 7'd16;

	localparam logic [4:0] FIELD_LIMIT = 5'd16;
	localparam logic [6:0] FLEN_LIMIT  = 7'd64;

	// clamped configuration as seen by the parser
	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [7:0]  max_line_length;
		logic [4:0]  eff_fields;
		logic [6:0]  eff_field_len;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  field_char;
		logic [3:0]  field_index;
		logic [5:0]  char_position;
		logic [4:0]  field_count;
	} result_t;

endpackage

// File: hw/rtl/lfs_cfg.sv
// Configuration registers with range clamping.
module lfs_cfg import lfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	logic [15:0] timeout_q;
	logic [7:0]  max_line_q;
	logic [4:0]  max_fields_q;
	logic [6:0]  max_flen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RST;
			max_line_q   <= MAX_LINE_RST;
			max_fields_q <= MAX_FIELDS_RST;
			max_flen_q   <= MAX_FLEN_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_TIMEOUT:    timeout_q    <= cfg_wdata;
				REG_MAX_LINE:   max_line_q   <= cfg_wdata[7:0];
				REG_MAX_FIELDS: max_fields_q <= cfg_wdata[4:0];
				REG_MAX_FLEN:   max_flen_q   <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.timeout_ticks   = timeout_q;
		cfg.max_line_length = max_line_q;
		if (max_fields_q == 5'd0)
			cfg.eff_fields = 5'd1;
		else if (max_fields_q > FIELD_LIMIT)
			cfg.eff_fields = FIELD_LIMIT;
		else
			cfg.eff_fields = max_fields_q;
		if (max_flen_q == 7'd0)
			cfg.eff_field_len = 7'd1;
		else if (max_flen_q > FLEN_LIMIT)
			cfg.eff_field_len = FLEN_LIMIT;
		else
			cfg.eff_field_len = max_flen_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg.eff_fields != 5'd0 && cfg.eff_fields <= FIELD_LIMIT)
		else $error("field limit out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg.eff_field_len != 7'd0 && cfg.eff_field_len <= FLEN_LIMIT)
		else $error("field length limit out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_addr == REG_TIMEOUT |=> cfg.timeout_ticks == $past(cfg_wdata))
		else $error("timeout write lost");

endmodule

// File: hw/rtl/lfs_parse.sv
// Line parser state and per-item step logic.
module lfs_parse import lfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       mode,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output result_t    res
);

	logic        in_line_q, in_line_d;
	logic [7:0]  line_bytes_q, line_bytes_d;
	logic [7:0]  held_byte_q, held_byte_d;
	logic        held_valid_q, held_valid_d;
	logic [4:0]  field_q, field_d;
	logic [6:0]  pos_q, pos_d;
	logic [15:0] ticks_q, ticks_d;

	logic [8:0]  lb_inc;
	logic [15:0] ticks_inc;
	logic [6:0]  pos_inc;
	logic [4:0]  field_next;
	logic [5:0]  cnt;
	logic        kept;

	always_comb begin
		lb_inc     = {1'b0, line_bytes_q} + 9'd1;
		ticks_inc  = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
		pos_inc    = pos_q + 7'd1;
		field_next = (field_q < FIELD_LIMIT) ? field_q + 5'd1 : field_q;
		cnt        = {1'b0, field_q} + 6'd1;
		if (cnt > {1'b0, cfg.eff_fields})
			cnt = {1'b0, cfg.eff_fields};
		kept       = field_q < cfg.eff_fields;

		in_line_d    = in_line_q;
		line_bytes_d = line_bytes_q;
		held_byte_d  = held_byte_q;
		held_valid_d = held_valid_q;
		field_d      = field_q;
		pos_d        = pos_q;
		ticks_d      = ticks_q;
		res          = '0;
		res.status   = ST_NONE;

		if (!in_line_q) begin
			if (!mode) begin
				if (rx_byte != CH_LT) begin
					res.status = ST_BEGIN;
				end else begin
					line_bytes_d = 8'd1;
					ticks_d      = '0;
					held_byte_d  = '0;
					held_valid_d = 1'b0;
					field_d      = '0;
					pos_d        = '0;
					if (cfg.max_line_length <= 8'd1)
						res.status = ST_LONG;
					else
						in_line_d = 1'b1;
				end
			end
		end else if (mode) begin
			ticks_d = ticks_inc;
			if (ticks_inc >= cfg.timeout_ticks) begin
				in_line_d  = 1'b0;
				res.status = ST_TIMEOUT;
			end
		end else if (rx_byte == CH_NL) begin
			in_line_d = 1'b0;
			if (held_valid_q && held_byte_q == CH_GT) begin
				res.status      = ST_OK;
				res.field_count = cnt[4:0];
			end else begin
				res.status = ST_END;
			end
		end else begin
			line_bytes_d = lb_inc[7:0];
			if (lb_inc >= {1'b0, cfg.max_line_length}) begin
				in_line_d  = 1'b0;
				res.status = ST_LONG;
			end else begin
				if (held_valid_q) begin
					if (held_byte_q == CH_COMMA) begin
						if (kept) begin
							res.status      = ST_FEND;
							res.field_index = field_q[3:0];
						end
						field_d = field_next;
						pos_d   = '0;
					end else begin
						if (kept) begin
							res.status        = ST_CHAR;
							res.field_char    = held_byte_q;
							res.field_index   = field_q[3:0];
							res.char_position = pos_q[5:0];
						end
						// a full field rolls into the next one without a field end
						if (pos_inc >= cfg.eff_field_len) begin
							field_d = field_next;
							pos_d   = '0;
						end else begin
							pos_d = pos_inc;
						end
					end
				end
				held_byte_d  = rx_byte;
				held_valid_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q    <= 1'b0;
			line_bytes_q <= '0;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			field_q      <= '0;
			pos_q        <= '0;
			ticks_q      <= '0;
		end else if (step) begin
			in_line_q    <= in_line_d;
			line_bytes_q <= line_bytes_d;
			held_byte_q  <= held_byte_d;
			held_valid_q <= held_valid_d;
			field_q      <= field_d;
			pos_q        <= pos_d;
			ticks_q      <= ticks_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) field_q <= FIELD_LIMIT)
		else $error("field index overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pos_q < FLEN_LIMIT)
		else $error("field position overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_line_q |-> (line_bytes_q != 8'd0 && line_bytes_q != 8'hFF))
		else $error("line byte count out of range inside a line");
	assert property (@(posedge clk) disable iff (!arst_n)
		step && !in_line_q && !mode && rx_byte == CH_LT |=> ticks_q == 16'd0 && !held_valid_q)
		else $error("line start did not clear counters");

endmodule

// File: hw/rtl/delimited_line_field_splitter.sv
// Top level: input register, line parser, result register.
// Throughput: one item per cycle unless m_tready stalls the output, set by the
// combinational parser step between the input register and the result register;
// every item yields exactly one result.
// Reset (arst_n low, asynchronous): both stages empty, parser idle, registers at
// their documented defaults.
module delimited_line_field_splitter import lfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] field_char, [11:8] field_index,
	                               // [17:12] char_position, [22:18] field_count, [23] zero
	output logic [2:0]  m_tuser,   // [2:0] status
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	cfg_t       cfg;
	result_t    res;
	result_t    res_s2;
	logic       valid_s1, valid_s2;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic       out_ready;
	logic       adv;

	assign out_ready = !valid_s2 || m_tready;
	assign adv       = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;

	lfs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lfs_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.mode    (mode_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (out_ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
		if (adv)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.status;
	assign m_tdata  = {1'b0, res_s2.field_count, res_s2.char_position,
	                   res_s2.field_index, res_s2.field_char};

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status == ST_OK |-> res_s2.field_count != 5'd0)
		else $error("line ok with zero fields");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_ready |=> valid_s1 && $stable(byte_s1) && $stable(mode_s1))
		else $error("input stage lost a stalled item");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(adv))
		else $error("result without parser step");

endmodule

// File: test/tb_delimited_line_field_splitter.sv
// Self-checking testbench for the delimited line field splitter.
module tb_delimited_line_field_splitter;
	import lfs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;

	delimited_line_field_splitter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// register copies
	logic [15:0] lim_timeout;
	logic [7:0]  lim_line;
	logic [4:0]  lim_fields;
	logic [6:0]  lim_flen;

	// parser state copy
	logic        p_in_line;
	logic [8:0]  p_line_bytes;
	logic [7:0]  p_held;
	logic        p_held_ok;
	logic [4:0]  p_field;
	logic [6:0]  p_pos;
	logic [15:0] p_ticks;

	result_t     pending_results[$];
	result_t     exp_r;
	result_t     got_r;
	int          mismatches = 0;
	int          items_sent = 0;
	int          burst_left = 4;
	int unsigned quiet_cycles = 0;
	int unsigned stall_cnt = 0;
	int          stall_style = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [4:0] eff_fields();
		if (lim_fields < 5'd1) return 5'd1;
		if (lim_fields > FIELD_LIMIT) return FIELD_LIMIT;
		return lim_fields;
	endfunction

	function automatic logic [6:0] eff_flen();
		if (lim_flen < 7'd1) return 7'd1;
		if (lim_flen > FLEN_LIMIT) return FLEN_LIMIT;
		return lim_flen;
	endfunction

	function automatic void open_next_field();
		if (p_field < FIELD_LIMIT) p_field++;
		p_pos = '0;
	endfunction

	// one parser step: updates the state copy, returns the result of the item
	function automatic result_t split_step(input logic mode, input logic [7:0] b);
		result_t r;
		int      cnt;
		logic    kept;
		r = '0;
		if (!p_in_line) begin
			if (mode) return r;
			if (b != CH_LT) begin
				r.status = ST_BEGIN;
				return r;
			end
			p_in_line = 1'b1;
			p_line_bytes = 9'd1;
			p_ticks = '0;
			p_held = '0;
			p_held_ok = 1'b0;
			p_field = '0;
			p_pos = '0;
			if (p_line_bytes >= lim_line) begin
				p_in_line = 1'b0;
				r.status = ST_LONG;
			end
			return r;
		end
		if (mode) begin
			if (p_ticks != 16'hFFFF) p_ticks++;
			if (p_ticks >= lim_timeout) begin
				p_in_line = 1'b0;
				r.status = ST_TIMEOUT;
			end
			return r;
		end
		if (b == CH_NL) begin
			p_in_line = 1'b0;
			if (p_held_ok && p_held == CH_GT) begin
				cnt = int'(p_field) + 1;
				if (cnt > int'(eff_fields())) cnt = int'(eff_fields());
				r.status = ST_OK;
				r.field_count = cnt[4:0];
			end else begin
				r.status = ST_END;
			end
			return r;
		end
		if (p_line_bytes < 9'd255) p_line_bytes++;
		else p_line_bytes = 9'd256;
		if (p_line_bytes >= lim_line) begin
			p_in_line = 1'b0;
			r.status = ST_LONG;
			return r;
		end
		if (p_held_ok) begin
			kept = p_field < eff_fields();
			if (p_held == CH_COMMA) begin
				if (kept) begin
					r.status = ST_FEND;
					r.field_index = p_field[3:0];
				end
				open_next_field();
			end else begin
				if (kept) begin
					r.status = ST_CHAR;
					r.field_char = p_held;
					r.field_index = p_field[3:0];
					r.char_position = p_pos[5:0];
				end
				p_pos++;
				// full-length field closes without a field end
				if (p_pos >= eff_flen()) open_next_field();
			end
		end
		p_held = b;
		p_held_ok = 1'b1;
		return r;
	endfunction

	task automatic log_error(input string what, input result_t e, input result_t g);
		mismatches++;
		if (mismatches <= 10)
			$display({"%s: expected st %0d ch %02h idx %0d pos %0d cnt %0d, ",
				"got st %0d ch %02h idx %0d pos %0d cnt %0d"},
				what, e.status, e.field_char, e.field_index, e.char_position,
				e.field_count, g.status, g.field_char, g.field_index,
				g.char_position, g.field_count);
	endtask

	// result checker and idle watchdog
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got_r.status = status_t'(m_tuser);
			got_r.field_char = m_tdata[7:0];
			got_r.field_index = m_tdata[11:8];
			got_r.char_position = m_tdata[17:12];
			got_r.field_count = m_tdata[22:18];
			if (pending_results.size() == 0) begin
				log_error("unexpected item", '0, got_r);
			end else begin
				exp_r = pending_results.pop_front();
				if (got_r !== exp_r) log_error("mismatch", exp_r, got_r);
			end
		end
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_delimited_line_field_splitter: errors");
				$finish;
			end
		end
	end

	// receiver backpressure, style picked anew at random whenever stall_cnt[5:0] is zero
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (stall_cnt[5:0] == 6'd0) stall_style <= $urandom_range(0, 3);
		case (stall_style)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ((stall_cnt % 5) != 0);
			default: m_tready <= stall_cnt[3];
		endcase
	end

	task automatic send_item(input logic mode, input logic [7:0] b);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= mode;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(split_step(mode, b));
		items_sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 10);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
	endtask

	// stop sending, wait for every expected item, then let the pipeline settle
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_TIMEOUT:    lim_timeout = val;
			REG_MAX_LINE:   lim_line = val[7:0];
			REG_MAX_FIELDS: lim_fields = val[4:0];
			REG_MAX_FLEN:   lim_flen = val[6:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] tmo, input logic [7:0] line,
	                        input logic [4:0] fields, input logic [6:0] flen);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_MAX_LINE, {8'd0, line});
		write_reg(REG_MAX_FIELDS, {11'd0, fields});
		write_reg(REG_MAX_FLEN, {9'd0, flen});
	endtask

	// byte of a line, now and then preceded by a tick
	task automatic send_line_byte(input logic [7:0] b);
		if ($urandom_range(0, 11) == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
		send_item(1'b0, b);
	endtask

	// mostly well-formed lines with random content, some noise and broken lines
	task automatic send_random_line();
		int         kind;
		int         nfields;
		int         flen_hi;
		int         len;
		logic [7:0] ch;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 4))
				send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			return;
		end
		// kind 1: no '<', kind 2: no '>', kind 3: no newline
		if (kind != 1) send_line_byte(CH_LT);
		nfields = $urandom_range(1, int'(eff_fields()) + 2);
		flen_hi = int'(eff_flen()) + 4;
		for (int i = 0; i < nfields; i++) begin
			if (i != 0) send_line_byte(CH_COMMA);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, flen_hi) : $urandom_range(0, 6);
			for (int j = 0; j < len; j++) begin
				ch = 8'($urandom_range(0, 255));
				if (ch == CH_NL && $urandom_range(0, 3) != 0) ch = 8'h2E;
				send_line_byte(ch);
			end
		end
		if (kind != 2) send_line_byte(CH_GT);
		if (kind != 3) send_line_byte(CH_NL);
	endtask

	task automatic run_lines(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) send_random_line();
		wait_for_results();
	endtask

	task automatic test_idle_and_bad_begin();
		send_item(1'b1, 8'hFF);
		send_item(1'b0, 8'h00);
		wait_for_results();
	endtask

	task automatic test_line_ok_and_bad_end();
		send_text("<a,b>\n");
		send_item(1'b0, CH_LT);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, CH_NL);
		wait_for_results();
	endtask

	// one field kept, one-char fields, short lines, two-tick timeout
	task automatic test_limits();
		set_regs(16'd2, 8'd6, 5'd1, 7'd1);
		send_text("<ab>\n");
		send_item(1'b0, CH_LT);
		send_item(1'b1, 8'h00);
		send_item(1'b1, 8'h00);
		send_text("<abcde");
		wait_for_results();
	endtask

	task automatic test_random_default();
		set_regs(TIMEOUT_RST, MAX_LINE_RST, MAX_FIELDS_RST, MAX_FLEN_RST);
		run_lines(250);
	endtask

	task automatic test_random_tight();
		repeat (2) begin
			set_regs(16'($urandom_range(3, 60)), 8'($urandom_range(3, 40)),
			         5'($urandom_range(1, 6)), 7'($urandom_range(1, 8)));
			run_lines(125);
		end
	endtask

	task automatic test_random_wide();
		set_regs(16'hFFFF, 8'd255, 5'd16, 7'd64);
		run_lines(200);
		set_regs(16'd1, 8'd2, 5'd1, 7'd1);
		run_lines(40);
	endtask

	// field and field-length values outside the documented ranges are clamped by the block
	task automatic test_register_extremes();
		set_regs(16'd0, 8'd1, 5'd0, 7'd0);
		run_lines(30);
		set_regs(16'd0, 8'd255, 5'd31, 7'd127);
		run_lines(100);
		set_regs(16'd700, 8'd180, 5'd0, 7'd0);
		run_lines(120);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		lim_timeout = TIMEOUT_RST;
		lim_line = MAX_LINE_RST;
		lim_fields = MAX_FIELDS_RST;
		lim_flen = MAX_FLEN_RST;
		p_in_line = 1'b0;
		p_line_bytes = '0;
		p_held = '0;
		p_held_ok = 1'b0;
		p_field = '0;
		p_pos = '0;
		p_ticks = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_and_bad_begin();
		test_line_ok_and_bad_end();
		test_limits();
		test_random_default();
		test_random_tight();
		test_random_wide();
		test_register_extremes();

		if (mismatches == 0) begin
			$display("tb_delimited_line_field_splitter: clean");
		end else begin
			$display("tb_delimited_line_field_splitter: errors");
		end
		$finish;
	end

endmodule
